// File: rtl/brc_pkg.sv
// Package for the bond record checker: record constants, the queue entry
// type and the byte-wide CRC-32 update. No dependencies.
`timescale 1ns / 1ps

package brc_pkg;

   localparam int CNT_W     = 5;
   localparam int CAP_DEPTH = 22;
   localparam int Q_DEPTH   = 2;

   typedef logic [CNT_W-1:0] cnt_type;

   localparam logic [31:0] REC_MAGIC = 32'h3242_4e4d;
   localparam logic [31:0] CRC_POLY  = 32'hedb8_8320;
   localparam logic [31:0] CRC_INIT  = 32'hffff_ffff;

   localparam cnt_type LEGACY_CRC_AT  = 5'd16;
   localparam cnt_type CURRENT_CRC_AT = 5'd18;
   localparam cnt_type LEGACY_LEN     = 5'd20;
   localparam cnt_type CURRENT_LEN    = 5'd22;
   localparam cnt_type COUNT_SAT      = 5'd23;

   localparam logic [15:0] SCHEMA_ID_LEGACY  = 16'd1;
   localparam logic [15:0] SCHEMA_ID_CURRENT = 16'd2;
   localparam logic [7:0]  FLAG_SC           = 8'h01;
   localparam logic [7:0]  KEY_LENGTH_REQ    = 8'd16;
   localparam logic [7:0]  LEVEL_MIN         = 8'd2;
   localparam logic [7:0]  LEVEL_MAX         = 8'd4;
   localparam logic [7:0]  ADDR_TYPE_MAX     = 8'd1;

   typedef enum logic [1:0] {
      SCHEMA_BAD,
      SCHEMA_LEGACY,
      SCHEMA_CURRENT
   } schema_type;

   // One finished record as the front hands it over.
   typedef struct packed {
      schema_type  kind;
      logic [31:0] crc_computed;
      logic [31:0] crc_stored;
      logic [7:0]  addr_type;
      logic [47:0] address;
      logic [7:0]  key_length;
      logic [7:0]  level;
      logic [7:0]  flags;
      logic [15:0] rev_stored;
   } rec_entry_type;

   typedef struct packed {
      logic          push;
      rec_entry_type entry;
   } q_push_type;

   typedef struct packed {
      logic          empty;
      rec_entry_type entry;
   } q_head_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
      end
      return c;
   endfunction

endpackage

// File: rtl/brc_req_if.sv
// Byte channel into the bond record checker: valid, ready and one record byte.
// No dependencies.
`timescale 1ns / 1ps

interface brc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] record_byte;
   logic       last_byte;

   modport source (output valid, output record_byte, output last_byte, input ready);
   modport sink   (input valid, input record_byte, input last_byte, output ready);
endinterface

// File: rtl/brc_rsp_if.sv
// Verdict channel out of the bond record checker: valid, ready and the result.
// No dependencies.
`timescale 1ns / 1ps

interface brc_rsp_if;
   logic        valid;
   logic        ready;
   logic        record_ok;
   logic        legacy_schema;
   logic        peer_type;
   logic [47:0] peer_address;
   logic [4:0]  key_length;
   logic [2:0]  sec_level;
   logic [7:0]  flag_bits;
   logic [15:0] revision;

   modport source (output valid, output record_ok, output legacy_schema, output peer_type,
                   output peer_address, output key_length, output sec_level,
                   output flag_bits, output revision, input ready);
   modport sink   (input valid, input record_ok, input legacy_schema, input peer_type,
                   input peer_address, input key_length, input sec_level,
                   input flag_bits, input revision, output ready);
endinterface

// File: rtl/brc_front.sv
// Front of the bond record checker: takes bytes, runs the CRC, captures the
// record and classifies it on the last byte. Depends on brc_pkg, brc_req_if.
`timescale 1ns / 1ps

module brc_front
   import brc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   brc_req_if.sink       req_if,
   input  logic          q_full,
   output q_push_type    q_push
);

   cnt_type     count_ff, count_in, count_step;
   logic [31:0] crc_ff, crc_in, crc_upd;
   logic [31:0] snap16_ff, snap16_in;
   logic [31:0] snap18_ff, snap18_in;
   logic [7:0]  cap_ff [CAP_DEPTH];
   logic [7:0]  cap_nx [CAP_DEPTH];
   logic        accept;
   logic        magic_ok;
   logic [15:0] schema_id;
   rec_entry_type entry;

   assign req_if.ready = !q_full;
   assign accept       = req_if.valid && !q_full;

   always_comb begin
      crc_upd = crc_ff;
      if (count_ff < CNT_W'(CAP_DEPTH)) begin
         crc_upd = crc_byte(crc_ff, req_if.record_byte);
      end
      count_step = (count_ff < COUNT_SAT) ? count_ff + 5'd1 : count_ff;
      for (int i = 0; i < CAP_DEPTH; i++) begin
         cap_nx[i] = (count_ff == CNT_W'(i)) ? req_if.record_byte : cap_ff[i];
      end

      count_in  = count_ff;
      crc_in    = crc_ff;
      snap16_in = snap16_ff;
      snap18_in = snap18_ff;
      if (accept) begin
         if (count_step == LEGACY_CRC_AT) begin
            snap16_in = ~crc_upd;
         end
         if (count_step == CURRENT_CRC_AT) begin
            snap18_in = ~crc_upd;
         end
         if (req_if.last_byte) begin
            count_in = '0;
            crc_in   = CRC_INIT;
         end else begin
            count_in = count_step;
            crc_in   = crc_upd;
         end
      end
   end

   // Classification of the finished record. Valid lengths are 20 and 22, so
   // the snapshots are already in their registers by the last byte.
   always_comb begin
      magic_ok  = {cap_nx[3], cap_nx[2], cap_nx[1], cap_nx[0]} == REC_MAGIC;
      schema_id = {cap_nx[5], cap_nx[4]};

      entry.kind = SCHEMA_BAD;
      if (magic_ok && schema_id == SCHEMA_ID_LEGACY && count_step == LEGACY_LEN) begin
         entry.kind = SCHEMA_LEGACY;
      end else if (magic_ok && schema_id == SCHEMA_ID_CURRENT && count_step == CURRENT_LEN) begin
         entry.kind = SCHEMA_CURRENT;
      end

      if (entry.kind == SCHEMA_LEGACY) begin
         entry.crc_computed = snap16_ff;
         entry.crc_stored   = {cap_nx[19], cap_nx[18], cap_nx[17], cap_nx[16]};
      end else begin
         entry.crc_computed = snap18_ff;
         entry.crc_stored   = {cap_nx[21], cap_nx[20], cap_nx[19], cap_nx[18]};
      end
      entry.addr_type  = cap_nx[6];
      entry.address    = {cap_nx[12], cap_nx[11], cap_nx[10], cap_nx[9], cap_nx[8], cap_nx[7]};
      entry.key_length = cap_nx[13];
      entry.level      = cap_nx[14];
      entry.flags      = cap_nx[15];
      entry.rev_stored = {cap_nx[17], cap_nx[16]};
   end

   assign q_push.push  = accept && req_if.last_byte;
   assign q_push.entry = entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         crc_ff    <= CRC_INIT;
         snap16_ff <= '0;
         snap18_ff <= '0;
      end else begin
         count_ff  <= count_in;
         crc_ff    <= crc_in;
         snap16_ff <= snap16_in;
         snap18_ff <= snap18_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < CAP_DEPTH; i++) begin
            cap_ff[i] <= cap_nx[i];
         end
      end
   end

endmodule

// File: rtl/brc_queue.sv
// Two-entry queue of classified records between front and back.
// Depends on brc_pkg.
`timescale 1ns / 1ps

module brc_queue
   import brc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  q_push_type q_push,
   input  logic       q_pop,
   output logic       q_full,
   output q_head_type q_head
);

   rec_entry_type mem_ff [Q_DEPTH];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    level_ff, level_in;
   logic          do_push, do_pop;

   assign q_full       = level_ff == 2'(Q_DEPTH);
   assign q_head.empty = level_ff == 2'd0;
   assign q_head.entry = mem_ff[rd_ptr_ff];

   always_comb begin
      do_push   = q_push.push && !q_full;
      do_pop    = q_pop && !q_head.empty;
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      level_in  = level_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         level_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= q_push.entry;
      end
   end

endmodule

// File: rtl/brc_back.sv
// Back of the bond record checker: final checks on a queued record and the
// registered verdict. Depends on brc_pkg, brc_rsp_if.
`timescale 1ns / 1ps

module brc_back
   import brc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] expected_revision,
   input  q_head_type  q_head,
   output logic        q_pop,
   brc_rsp_if.source   rsp_if
);

   logic          valid_ff, valid_in;
   logic          ok_ff, legacy_ff, ptype_ff;
   logic [47:0]   addr_ff;
   logic [4:0]    key_ff;
   logic [2:0]    level_ff;
   logic [7:0]    flags_ff;
   logic [15:0]   rev_ff;
   logic          ok, legacy;
   rec_entry_type e;

   assign e      = q_head.entry;
   assign q_pop  = !q_head.empty && (!valid_ff || rsp_if.ready);
   assign legacy = e.kind == SCHEMA_LEGACY;

   always_comb begin
      ok = (e.kind != SCHEMA_BAD)
           && (e.crc_stored == e.crc_computed)
           && (e.addr_type <= ADDR_TYPE_MAX)
           && (e.key_length == KEY_LENGTH_REQ)
           && (e.level >= LEVEL_MIN) && (e.level <= LEVEL_MAX)
           && ((e.flags & FLAG_SC) != 8'd0)
           && (legacy || e.rev_stored == expected_revision);

      valid_in = valid_ff;
      if (q_pop) begin
         valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // A failed record shows all fields as zero.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         ok_ff     <= ok;
         legacy_ff <= ok && legacy;
         ptype_ff  <= ok && e.addr_type[0];
         addr_ff   <= ok ? e.address : '0;
         key_ff    <= ok ? e.key_length[4:0] : '0;
         level_ff  <= ok ? e.level[2:0] : '0;
         flags_ff  <= ok ? e.flags : '0;
         rev_ff    <= ok ? expected_revision : '0;
      end
   end

   assign rsp_if.valid         = valid_ff;
   assign rsp_if.record_ok     = ok_ff;
   assign rsp_if.legacy_schema = legacy_ff;
   assign rsp_if.peer_type     = ptype_ff;
   assign rsp_if.peer_address  = addr_ff;
   assign rsp_if.key_length    = key_ff;
   assign rsp_if.sec_level     = level_ff;
   assign rsp_if.flag_bits     = flags_ff;
   assign rsp_if.revision      = rev_ff;

endmodule

// File: rtl/bond_record_checker.sv
// Top level of the bond record checker: revision register, front, queue and
// back. Depends on brc_pkg, brc_req_if, brc_rsp_if and the brc_ modules.
//
//  Channel   Direction  Transfer                      Payload
//  req_if    in         one record byte               record_byte, last_byte
//  rsp_if    out        one verdict per record        record_ok .. revision
//  csr_      in         write of expected_revision    csr_wr_data (16 bits)
//
// One byte is taken every cycle while the record queue has room; the byte-wide CRC
// update in the front sets that figure. The last byte's transfer writes the record
// queue, and the back loads its output register from the queue head once that
// register is free or being taken; the verdict then shows from that register.
// Reset is synchronous and clears the counter, CRC, snapshots, queue and
// output valid; the captured bytes are not cleared.
// A stalled result channel fills the two-entry record queue, after which
// req_if.ready stays low until the back can take a record from the queue.
`timescale 1ns / 1ps

module bond_record_checker
   import brc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   brc_req_if.sink     req_if,
   brc_rsp_if.source   rsp_if,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic [15:0] expected_revision_ff;
   q_push_type  q_push;
   q_head_type  q_head;
   logic        q_full;
   logic        q_pop;

   // The user must write the revision register only while no record is in flight; the block itself does not enforce it.
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_revision_ff <= '0;
      end else if (csr_wr_en) begin
         expected_revision_ff <= csr_wr_data;
      end
   end

   // The front runs the CRC and captures bytes; on the last byte it pushes a
   // classified record into the queue, so the next record may start at once.
   brc_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .q_full (q_full),
      .q_push (q_push)
   );

   brc_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .q_pop  (q_pop),
      .q_full (q_full),
      .q_head (q_head)
   );

   // The back finishes the CRC, field and revision checks and holds the verdict
   // until the result channel takes it.
   brc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .expected_revision (expected_revision_ff),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .rsp_if            (rsp_if)
   );

endmodule

// File: rtl/brc_checker.sv
// Port-level checks on the bond record checker's verdict channel, bound to
// the top level. Depends on bond_record_checker.
`timescale 1ns / 1ps

module brc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        record_ok,
   input logic        legacy_schema,
   input logic        peer_type,
   input logic [47:0] peer_address,
   input logic [4:0]  key_length,
   input logic [2:0]  sec_level,
   input logic [7:0]  flag_bits,
   input logic [15:0] revision
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(record_ok) && $stable(revision)
                                  && $stable(peer_address))
      else $error("verdict changed while stalled");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !record_ok |-> !legacy_schema && !peer_type && peer_address == 48'd0
                                  && key_length == 5'd0 && sec_level == 3'd0
                                  && flag_bits == 8'd0 && revision == 16'd0)
      else $error("failed record carries non-zero fields");

   a_ok_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && record_ok |-> key_length == 5'd16 && sec_level >= 3'd2
                                 && sec_level <= 3'd4 && flag_bits[0])
      else $error("accepted record with out-of-range fields");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("verdict valid after reset");

endmodule

bind bond_record_checker brc_checker u_brc_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .record_ok      (rsp_if.record_ok),
   .legacy_schema  (rsp_if.legacy_schema),
   .peer_type      (rsp_if.peer_type),
   .peer_address   (rsp_if.peer_address),
   .key_length     (rsp_if.key_length),
   .sec_level      (rsp_if.sec_level),
   .flag_bits      (rsp_if.flag_bits),
   .revision       (rsp_if.revision)
);

// File: test/tb_bond_record_checker.sv
// Self-checking testbench for bond_record_checker: streams whole and damaged bond records
// and compares every verdict against a behavioural model of the checker.
// Depends on brc_pkg, brc_req_if, brc_rsp_if and the RTL of bond_record_checker.
`timescale 1ns / 1ps

module tb_bond_record_checker;
   import brc_pkg::*;

   // The block takes one byte per cycle while its record queue has room and gives
   // its verdict through the queue and its output register after the last byte, so
   // DRAIN_CYCLES is ample to settle it before a register write and at the run's end.
   localparam int DRAIN_CYCLES    = 8;
   localparam int CYCLE_LIMIT     = 500000;
   localparam int HOLD_CYCLES     = 300;
   localparam int BYTES_PER_PHASE = 210;

   // Kinds of damage that can be done to an otherwise well-formed record.
   typedef enum int {
      FLT_NONE,
      FLT_CRC,
      FLT_MAGIC,
      FLT_SCHEMA,
      FLT_SWAP,
      FLT_ADDR_TYPE,
      FLT_KEY_LENGTH,
      FLT_LEVEL,
      FLT_FLAG_SC,
      FLT_REVISION,
      FLT_SHORT,
      FLT_LONG,
      FLT_OVERLONG,
      FLT_NOISE
   } fault_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } byte_item_type;

   typedef struct packed {
      logic        record_ok;
      logic        legacy_schema;
      logic        peer_type;
      logic [47:0] peer_address;
      logic [4:0]  key_length;
      logic [2:0]  sec_level;
      logic [7:0]  flag_bits;
      logic [15:0] revision;
   } verdict_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   brc_req_if req_if ();
   brc_rsp_if rsp_if ();

   bond_record_checker u_top (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Bytes waiting to be offered, and verdicts the model says must come out.
   byte_item_type pending_bytes[$];
   verdict_type   pending_verdicts[$];
   logic [7:0]    record_draft[$];

   // Model of the checker's own state. The revision setting is only changed while
   // the block is idle, so the model may take it over at the time of the write.
   logic [15:0] revision_setting = 16'd0;
   int          rec_len          = 0;
   logic [31:0] crc_run          = CRC_INIT;
   logic [31:0] crc_at_sixteen   = 32'd0;
   logic [31:0] crc_at_eighteen  = 32'd0;
   logic [7:0]  cap_bytes [0:21] = '{default: 8'h00};

   // Handshake bookkeeping for the clocked processes.
   bit req_busy     = 1'b0;
   bit random_phase = 1'b0;
   int req_gap_left = 0;
   int req_calm     = 0;
   int stall_left   = 0;
   int hold_left    = 0;
   int rsp_calm     = 0;
   int long_holds   = 0;

   int cycle_count      = 0;
   int error_count      = 0;
   int bytes_sent       = 0;
   int records_sent     = 0;
   int verdicts_seen    = 0;
   int records_accepted = 0;
   int records_rejected = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Reflected CRC-32, one bit at a time: a bit leaving the low end that differs
   // from the incoming data bit folds the polynomial back in.
   function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] d);
      logic [31:0] c;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         if (c[0] ^ d[i]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   // Advances the model by one byte. Returns 1 when the byte closes a record, with
   // the verdict that the block must give for it.
   function automatic bit verdict_for_byte(input logic [7:0] b, input logic last,
                                           output verdict_type v);
      int          len;
      logic [15:0] schema;
      logic [31:0] stored;
      logic [31:0] computed;
      logic [15:0] rev;
      bit          ok;
      v = '0;
      if (rec_len < CURRENT_LEN) begin
         cap_bytes[rec_len] = b;
         crc_run = crc32_update(crc_run, b);
      end
      if (rec_len < COUNT_SAT) begin
         rec_len++;
      end
      if (rec_len == LEGACY_CRC_AT) begin
         crc_at_sixteen = ~crc_run;
      end
      if (rec_len == CURRENT_CRC_AT) begin
         crc_at_eighteen = ~crc_run;
      end
      if (!last) begin
         return 1'b0;
      end

      // The record is over: the counter and the CRC start afresh for the next one.
      len     = rec_len;
      rec_len = 0;
      crc_run = CRC_INIT;

      if (len != LEGACY_LEN && len != CURRENT_LEN) begin
         return 1'b1;
      end
      if ({cap_bytes[3], cap_bytes[2], cap_bytes[1], cap_bytes[0]} != REC_MAGIC) begin
         return 1'b1;
      end
      schema = {cap_bytes[5], cap_bytes[4]};
      if (schema == SCHEMA_ID_LEGACY) begin
         if (len != LEGACY_LEN) begin
            return 1'b1;
         end
         stored   = {cap_bytes[19], cap_bytes[18], cap_bytes[17], cap_bytes[16]};
         computed = crc_at_sixteen;
         rev      = revision_setting;
      end else if (schema == SCHEMA_ID_CURRENT) begin
         if (len != CURRENT_LEN) begin
            return 1'b1;
         end
         stored   = {cap_bytes[21], cap_bytes[20], cap_bytes[19], cap_bytes[18]};
         computed = crc_at_eighteen;
         rev      = {cap_bytes[17], cap_bytes[16]};
      end else begin
         return 1'b1;
      end

      ok = (stored == computed) && (cap_bytes[6] <= ADDR_TYPE_MAX)
           && (cap_bytes[13] == KEY_LENGTH_REQ)
           && (cap_bytes[14] >= LEVEL_MIN) && (cap_bytes[14] <= LEVEL_MAX)
           && ((cap_bytes[15] & FLAG_SC) != 8'd0) && (rev == revision_setting);
      if (!ok) begin
         return 1'b1;
      end

      v.record_ok     = 1'b1;
      v.legacy_schema = (schema == SCHEMA_ID_LEGACY);
      v.peer_type     = cap_bytes[6][0];
      v.peer_address  = {cap_bytes[12], cap_bytes[11], cap_bytes[10],
                         cap_bytes[9], cap_bytes[8], cap_bytes[7]};
      v.key_length    = cap_bytes[13][4:0];
      v.sec_level     = cap_bytes[14][2:0];
      v.flag_bits     = cap_bytes[15];
      v.revision      = rev;
      return 1'b1;
   endfunction

   // Gap lengths: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   task automatic flag_error(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [47:0] got,
                              input logic [47:0] want);
      if (got !== want) begin
         flag_error($sformatf("verdict %0d, %s is %h, model says %h",
                              verdicts_seen, name, got, want));
      end
   endtask

   // Builds one record and appends its bytes to the pending queue. A corner of 1
   // or 2 pins the fields at their lowest or highest legal values; 0 draws them.
   // Field damage goes in before the CRC is sealed, so that only the damaged
   // field is wrong; CRC and length damage come afterwards.
   task automatic queue_record(input bit legacy, input fault_type fault, input int corner);
      int            crc_at;
      int            k;
      int            keep;
      logic [7:0]    b;
      logic [15:0]   sch;
      logic [31:0]   crc;
      byte_item_type item;

      crc_at = legacy ? int'(LEGACY_CRC_AT) : int'(CURRENT_CRC_AT);
      record_draft.delete();
      for (int i = 0; i < 4; i++) begin
         record_draft.push_back(REC_MAGIC[8*i +: 8]);
      end
      sch = legacy ? SCHEMA_ID_LEGACY : SCHEMA_ID_CURRENT;
      record_draft.push_back(sch[7:0]);
      record_draft.push_back(sch[15:8]);
      b = (corner == 0) ? 8'($urandom_range(0, 1)) : ((corner == 1) ? 8'd0 : 8'd1);
      record_draft.push_back(b);
      for (int i = 0; i < 6; i++) begin
         b = (corner == 0) ? 8'($urandom) : ((corner == 1) ? 8'h00 : 8'hff);
         record_draft.push_back(b);
      end
      record_draft.push_back(KEY_LENGTH_REQ);
      b = (corner == 0) ? 8'($urandom_range(LEVEL_MIN, LEVEL_MAX))
                        : ((corner == 1) ? LEVEL_MIN : LEVEL_MAX);
      record_draft.push_back(b);
      b = 8'($urandom);
      b = (corner == 0) ? (b | FLAG_SC) : ((corner == 1) ? FLAG_SC : 8'hff);
      record_draft.push_back(b);
      if (!legacy) begin
         record_draft.push_back(revision_setting[7:0]);
         record_draft.push_back(revision_setting[15:8]);
      end

      case (fault)
         FLT_MAGIC: begin
            k = $urandom_range(0, 3);
            b = 8'($urandom_range(1, 255));
            record_draft[k] = record_draft[k] ^ b;
         end
         FLT_SCHEMA: begin
            case ($urandom_range(0, 3))
               0:       sch = 16'd0;
               1:       sch = 16'd3;
               2:       sch = 16'h0101;
               default: sch = 16'($urandom);
            endcase
            if (sch == SCHEMA_ID_LEGACY || sch == SCHEMA_ID_CURRENT) begin
               sch = 16'hffff;
            end
            record_draft[4] = sch[7:0];
            record_draft[5] = sch[15:8];
         end
         FLT_SWAP: begin
            record_draft[4] = legacy ? SCHEMA_ID_CURRENT[7:0] : SCHEMA_ID_LEGACY[7:0];
         end
         FLT_ADDR_TYPE: begin
            record_draft[6] = 8'($urandom_range(ADDR_TYPE_MAX + 1, 255));
         end
         FLT_KEY_LENGTH: begin
            b = $urandom_range(0, 1) ? 8'(KEY_LENGTH_REQ ^ (8'd1 << $urandom_range(0, 7)))
                                     : 8'($urandom);
            record_draft[13] = (b == KEY_LENGTH_REQ) ? 8'd0 : b;
         end
         FLT_LEVEL: begin
            record_draft[14] = $urandom_range(0, 1) ? 8'($urandom_range(0, LEVEL_MIN - 1))
                                                    : 8'($urandom_range(LEVEL_MAX + 1, 255));
         end
         FLT_FLAG_SC: begin
            record_draft[15] = record_draft[15] & ~FLAG_SC;
         end
         FLT_REVISION: begin
            // A legacy record has no revision of its own, so this does nothing there.
            if (!legacy) begin
               k = 16 + $urandom_range(0, 1);
               b = 8'($urandom_range(1, 255));
               record_draft[k] = record_draft[k] ^ b;
            end
         end
         default: begin
         end
      endcase

      crc = CRC_INIT;
      for (int i = 0; i < crc_at; i++) begin
         crc = crc32_update(crc, record_draft[i]);
      end
      crc = ~crc;
      for (int i = 0; i < 4; i++) begin
         record_draft.push_back(crc[8*i +: 8]);
      end

      case (fault)
         FLT_CRC: begin
            k = crc_at + $urandom_range(0, 3);
            b = 8'($urandom_range(1, 255));
            record_draft[k] = record_draft[k] ^ b;
         end
         FLT_SHORT: begin
            keep = $urandom_range(1, record_draft.size() - 1);
            while (record_draft.size() > keep) begin
               void'(record_draft.pop_back());
            end
         end
         FLT_LONG: begin
            // Legacy records grow to 21 or 22 bytes, current ones to 23.
            repeat (legacy ? $urandom_range(1, 2) : 1) begin
               b = 8'($urandom);
               record_draft.push_back(b);
            end
         end
         FLT_OVERLONG: begin
            repeat ($urandom_range(2, 24)) begin
               b = 8'($urandom);
               record_draft.push_back(b);
            end
         end
         FLT_NOISE: begin
            record_draft.delete();
            repeat ($urandom_range(1, 32)) begin
               b = 8'($urandom);
               record_draft.push_back(b);
            end
         end
         default: begin
         end
      endcase

      for (int i = 0; i < record_draft.size(); i++) begin
         item.data = record_draft[i];
         item.last = (i == record_draft.size() - 1);
         pending_bytes.push_back(item);
      end
   endtask

   // The register is written on a single edge; nothing is in flight at that time.
   task automatic write_revision(input logic [15:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      revision_setting = value;
   endtask

   task automatic wait_idle();
      while (pending_bytes.size() != 0 || req_busy || pending_verdicts.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Byte driver. A new byte is put on the channel at the falling edge once the
   // previous one has gone and its gap has run out; valid stays high between
   // back-to-back transfers.
   always @(negedge clock) begin
      if (!req_busy && req_gap_left == 0 && pending_bytes.size() > 0) begin
         req_if.valid       <= 1'b1;
         req_if.record_byte <= pending_bytes[0].data;
         req_if.last_byte   <= pending_bytes[0].last;
         req_busy = 1'b1;
         if (req_calm > 0) begin
            req_calm--;
            req_gap_left = 0;
         end else if ($urandom_range(0, 99) == 0) begin
            req_calm     = $urandom_range(30, 120);
            req_gap_left = 0;
         end else begin
            req_gap_left = pick_gap();
         end
      end else if (!req_busy) begin
         req_if.valid <= 1'b0;
         if (req_gap_left > 0) begin
            req_gap_left--;
         end
      end
   end

   // Byte transfers are taken at the rising edge and run through the model.
   always @(posedge clock) begin
      verdict_type v;
      if (!reset && req_if.valid && req_if.ready) begin
         if (verdict_for_byte(req_if.record_byte, req_if.last_byte, v)) begin
            pending_verdicts.push_back(v);
            records_sent++;
         end
         void'(pending_bytes.pop_front());
         req_busy = 1'b0;
         bytes_sent++;
      end
   end

   // Result-side ready. Short stalls come at random; once the random part has
   // begun the receiver also holds off for a long stretch, which fills the
   // block's record queue and must push back on the byte channel.
   always @(negedge clock) begin
      int s;
      if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_if.ready <= 1'b0;
      end else if (random_phase
                   && (long_holds == 0 || (long_holds < 4 && $urandom_range(0, 3999) == 0))) begin
         hold_left = HOLD_CYCLES - 1;
         long_holds++;
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_calm > 0) begin
            rsp_calm--;
            s = 0;
         end else if ($urandom_range(0, 99) == 0) begin
            rsp_calm = $urandom_range(20, 80);
            s = 0;
         end else begin
            s = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
         end
         if (s == 0) begin
            rsp_if.ready <= 1'b1;
         end else begin
            stall_left = s - 1;
            rsp_if.ready <= 1'b0;
         end
      end
   end

   // Verdict monitor: each transfer is held against the oldest expected verdict.
   always @(posedge clock) begin
      verdict_type got;
      verdict_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = {rsp_if.record_ok, rsp_if.legacy_schema, rsp_if.peer_type, rsp_if.peer_address,
                rsp_if.key_length, rsp_if.sec_level, rsp_if.flag_bits, rsp_if.revision};
         if (pending_verdicts.size() == 0) begin
            flag_error($sformatf("verdict %0d arrived with no record closed: %h",
                                 verdicts_seen, got));
         end else begin
            want = pending_verdicts.pop_front();
            check_field("record_ok", 48'(got.record_ok), 48'(want.record_ok));
            check_field("legacy_schema", 48'(got.legacy_schema), 48'(want.legacy_schema));
            check_field("peer_type", 48'(got.peer_type), 48'(want.peer_type));
            check_field("peer_address", got.peer_address, want.peer_address);
            check_field("key_length", 48'(got.key_length), 48'(want.key_length));
            check_field("sec_level", 48'(got.sec_level), 48'(want.sec_level));
            check_field("flag_bits", 48'(got.flag_bits), 48'(want.flag_bits));
            check_field("revision", 48'(got.revision), 48'(want.revision));
            if (want.record_ok) begin
               records_accepted++;
            end else begin
               records_rejected++;
            end
         end
         verdicts_seen++;
      end
   end

   // Watchdog over the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("run stopped after %0d cycles with %0d bytes and %0d verdicts outstanding",
                  cycle_count, pending_bytes.size(), pending_verdicts.size());
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      logic [15:0] phase_revs [0:3];
      bit          legacy;
      int          corner;
      fault_type   fault;

      req_if.valid       = 1'b0;
      req_if.record_byte = 8'd0;
      req_if.last_byte   = 1'b0;
      rsp_if.ready       = 1'b0;
      csr_wr_en          = 1'b0;
      csr_wr_data        = 16'd0;
      reset              = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, still at the reset revision of zero: well-formed records at both
      // field extremes per schema, one per damage kind, and three kinds on both schemas.
      queue_record(1'b1, FLT_NONE, 1);
      queue_record(1'b1, FLT_NONE, 2);
      queue_record(1'b0, FLT_NONE, 1);
      queue_record(1'b0, FLT_NONE, 2);
      for (int f = FLT_CRC; f <= FLT_NOISE; f++) begin
         queue_record(f[0], fault_type'(f), 0);
      end
      queue_record(1'b1, FLT_SWAP, 0);
      queue_record(1'b0, FLT_REVISION, 0);
      queue_record(1'b0, FLT_LONG, 0);
      wait_idle();

      // Top revision: a legacy record simply takes the setting, a current one must
      // carry it.
      write_revision(16'hffff);
      queue_record(1'b0, FLT_NONE, 2);
      queue_record(1'b1, FLT_NONE, 0);
      queue_record(1'b0, FLT_REVISION, 0);
      wait_idle();

      // Random part: mostly well-formed records with random content, the rest
      // damaged or plain noise, under a revision written anew for each phase.
      phase_revs[0] = 16'($urandom_range(1, 16'hfffe));
      phase_revs[1] = 16'h0000;
      phase_revs[2] = 16'hffff;
      phase_revs[3] = 16'($urandom_range(1, 16'hfffe));
      for (int p = 0; p < 4; p++) begin
         write_revision(phase_revs[p]);
         random_phase = 1'b1;
         while (pending_bytes.size() < BYTES_PER_PHASE) begin
            legacy = 1'($urandom_range(0, 1));
            corner = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 2) : 0;
            if ($urandom_range(0, 99) < 55) begin
               fault = FLT_NONE;
            end else begin
               fault = fault_type'($urandom_range(FLT_CRC, FLT_NOISE));
            end
            queue_record(legacy, fault, corner);
         end
         wait_idle();
      end

      $display("covered %0d records in %0d bytes: %0d accepted and %0d rejected verdicts",
               records_sent, bytes_sent, records_accepted, records_rejected);
      $display("revision set to 0, ffff, %h and %h; %0d long result hold-offs; %0d errors",
               phase_revs[0], phase_revs[3], long_holds, error_count);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
